// File: design/scjd_pkg.sv
// Shared types, constants and per-channel coefficient functions for the
// servo command joint decoder. No dependencies.
`default_nettype none

package scjd_pkg;

  // Result status codes, also used as the command kind in the queue.
  typedef enum logic [1:0] {
    ST_JOINT   = 2'd0,
    ST_RESET   = 2'd1,
    ST_BAD     = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  // Servo channel numbers
  localparam logic [2:0] CH_BASE      = 3'd0;
  localparam logic [2:0] CH_SHOULDER  = 3'd1;
  localparam logic [2:0] CH_ELBOW     = 3'd2;
  localparam logic [2:0] CH_WRIST     = 3'd3;
  localparam logic [2:0] CH_GRIPPER   = 3'd4;
  localparam logic [2:0] CH_WRIST_ROT = 3'd5;

  localparam int PULSE_W     = 16;
  localparam int CHAN_W      = 3;
  localparam int ANGLE_W     = 16;
  localparam int NUM_JOINTS  = 7;
  localparam int WIN_W       = 12;   // window bounds
  localparam int DIFF_W      = 11;   // clamped pulse offset, also span
  localparam int RAD_W       = 32;   // radian span in Q30
  localparam int PROD_W      = 43;   // RAD_W + DIFF_W
  localparam int N_W         = 45;   // signed numerator
  localparam int MP_W        = 28;   // offset quotient numerator
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 32;
  localparam int Q_W         = 18;
  localparam int OFF_SHIFT   = 16;   // bias that keeps the numerator positive
  localparam int RAD_FRAC    = 30;   // radian constants are Q30

  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CMD_FIFO_DEPTH      = 4;
  localparam int ANGLE_MAX           = 32767;
  localparam int ANGLE_MIN           = -32768;

  // Command handed from the parser to the angle pipe
  typedef struct packed {
    status_t               status;
    logic [CHAN_W-1:0]     chan;
    logic [PULSE_W-1:0]    pulse;
  } cmd_t;

  // Pulse windows
  localparam int LO_BASE = 640,  HI_BASE = 2360;
  localparam int LO_SHLD = 800,  HI_SHLD = 1800;
  localparam int LO_ELBW = 680,  HI_ELBW = 1920;
  localparam int LO_WRST = 630,  HI_WRST = 2430;
  localparam int LO_GRIP = 850,  HI_GRIP = 2300;
  localparam int LO_WROT = 700,  HI_WROT = 2400;

  localparam int SPAN_BASE = HI_BASE - LO_BASE;
  localparam int SPAN_SHLD = HI_SHLD - LO_SHLD;
  localparam int SPAN_ELBW = HI_ELBW - LO_ELBW;
  localparam int SPAN_WRST = HI_WRST - LO_WRST;
  localparam int SPAN_GRIP = HI_GRIP - LO_GRIP;
  localparam int SPAN_WROT = HI_WROT - LO_WROT;

  // ceil(2^32 / span)
  localparam longint RECIP_ONE = longint'(1) << RECIP_SHIFT;
  localparam longint RECIP_BASE = (RECIP_ONE + SPAN_BASE - 1) / SPAN_BASE;
  localparam longint RECIP_SHLD = (RECIP_ONE + SPAN_SHLD - 1) / SPAN_SHLD;
  localparam longint RECIP_ELBW = (RECIP_ONE + SPAN_ELBW - 1) / SPAN_ELBW;
  localparam longint RECIP_WRST = (RECIP_ONE + SPAN_WRST - 1) / SPAN_WRST;
  localparam longint RECIP_GRIP = (RECIP_ONE + SPAN_GRIP - 1) / SPAN_GRIP;
  localparam longint RECIP_WROT = (RECIP_ONE + SPAN_WROT - 1) / SPAN_WROT;

  // Radian endpoints, Q30
  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint SIXTH_PI_Q30 = 64'sd562209904;
  localparam longint THIRD_PI_Q30 = 64'sd1124419809;
  localparam longint TQ_PI_Q30    = 64'sd2529944570;
  localparam longint GRIP_Q30     = 64'sd21474836;

  function automatic logic [WIN_W-1:0] win_lo(input logic [CHAN_W-1:0] ch);
    case (ch)
      CH_SHOULDER:  return WIN_W'(LO_SHLD);
      CH_ELBOW:     return WIN_W'(LO_ELBW);
      CH_WRIST:     return WIN_W'(LO_WRST);
      CH_GRIPPER:   return WIN_W'(LO_GRIP);
      CH_WRIST_ROT: return WIN_W'(LO_WROT);
      default:      return WIN_W'(LO_BASE);
    endcase
  endfunction

  function automatic logic [WIN_W-1:0] win_hi(input logic [CHAN_W-1:0] ch);
    case (ch)
      CH_SHOULDER:  return WIN_W'(HI_SHLD);
      CH_ELBOW:     return WIN_W'(HI_ELBW);
      CH_WRIST:     return WIN_W'(HI_WRST);
      CH_GRIPPER:   return WIN_W'(HI_GRIP);
      CH_WRIST_ROT: return WIN_W'(HI_WROT);
      default:      return WIN_W'(HI_BASE);
    endcase
  endfunction

  function automatic logic [DIFF_W-1:0] win_span(input logic [CHAN_W-1:0] ch);
    case (ch)
      CH_SHOULDER:  return DIFF_W'(SPAN_SHLD);
      CH_ELBOW:     return DIFF_W'(SPAN_ELBW);
      CH_WRIST:     return DIFF_W'(SPAN_WRST);
      CH_GRIPPER:   return DIFF_W'(SPAN_GRIP);
      CH_WRIST_ROT: return DIFF_W'(SPAN_WROT);
      default:      return DIFF_W'(SPAN_BASE);
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] span_recip(input logic [CHAN_W-1:0] ch);
    case (ch)
      CH_SHOULDER:  return RECIP_W'(RECIP_SHLD);
      CH_ELBOW:     return RECIP_W'(RECIP_ELBW);
      CH_WRIST:     return RECIP_W'(RECIP_WRST);
      CH_GRIPPER:   return RECIP_W'(RECIP_GRIP);
      CH_WRIST_ROT: return RECIP_W'(RECIP_WROT);
      default:      return RECIP_W'(RECIP_BASE);
    endcase
  endfunction

  // rad_hi - rad_lo, the slope numerator
  function automatic logic [RAD_W-1:0] rad_span(input logic [CHAN_W-1:0] ch);
    case (ch)
      CH_SHOULDER:  return RAD_W'(SIXTH_PI_Q30 + THIRD_PI_Q30);
      CH_ELBOW:     return RAD_W'(TQ_PI_Q30);
      CH_GRIPPER:   return RAD_W'(2 * GRIP_Q30);
      default:      return RAD_W'(2 * HALF_PI_Q30);
    endcase
  endfunction

  // rad_lo * span + den / 2, den = span * 2^(30 - frac)
  function automatic logic signed [N_W-1:0] base_term(input longint rad_lo,
                                                      input longint span,
                                                      input int frac);
    longint t;
    t = rad_lo * span + (span <<< (RAD_FRAC - 1 - frac));
    return N_W'(t);
  endfunction

  function automatic logic signed [N_W-1:0] a_coef(input logic [CHAN_W-1:0] ch,
                                                   input int frac);
    case (ch)
      CH_SHOULDER:  return base_term(-THIRD_PI_Q30, SPAN_SHLD, frac);
      CH_ELBOW:     return base_term(64'sd0, SPAN_ELBW, frac);
      CH_WRIST:     return base_term(-HALF_PI_Q30, SPAN_WRST, frac);
      CH_GRIPPER:   return base_term(-GRIP_Q30, SPAN_GRIP, frac);
      CH_WRIST_ROT: return base_term(-HALF_PI_Q30, SPAN_WROT, frac);
      default:      return base_term(-HALF_PI_Q30, SPAN_BASE, frac);
    endcase
  endfunction

endpackage

`default_nettype wire

// File: design/scjd_parser.sv
// Front end: per-byte grammar check of a servo command message.
// Emits one cmd_t per message on its last byte. Uses scjd_pkg.
`default_nettype none

module scjd_parser (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          byte_accept,
  input  wire logic [7:0]                    msg_byte,
  input  wire logic                          end_of_message,
  output logic                               cmd_push,
  output scjd_pkg::cmd_t                     cmd
);
  import scjd_pkg::*;

  typedef enum logic [12:0] {
    PH_START = 13'b0000000000001,
    PH_RWORD = 13'b0000000000010,
    PH_CH1   = 13'b0000000000100,
    PH_CHN   = 13'b0000000001000,
    PH_CHWS  = 13'b0000000010000,
    PH_P1    = 13'b0000000100000,
    PH_PN    = 13'b0000001000000,
    PH_PWS   = 13'b0000010000000,
    PH_S1    = 13'b0000100000000,
    PH_SN    = 13'b0001000000000,
    PH_SWS   = 13'b0010000000000,
    PH_T1    = 13'b0100000000000,
    PH_TN    = 13'b1000000000000
  } phase_t;

  localparam logic [7:0] C_HASH  = 8'h23;
  localparam logic [7:0] C_ZERO  = 8'h30;
  localparam logic [7:0] C_NINE  = 8'h39;
  localparam logic [7:0] C_E     = 8'h45;
  localparam logic [7:0] C_P     = 8'h50;
  localparam logic [7:0] C_R     = 8'h52;
  localparam logic [7:0] C_S     = 8'h53;
  localparam logic [7:0] C_T     = 8'h54;
  localparam logic [7:0] C_SPACE = 8'h20;
  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_CR    = 8'h0d;
  localparam logic [2:0] RWORD_LEN = 3'd5;

  function automatic logic [7:0] rword_char(input logic [2:0] idx);
    case (idx)
      3'd0:    return C_R;
      3'd1:    return C_E;
      3'd2:    return C_S;
      3'd3:    return C_E;
      default: return C_T;
    endcase
  endfunction

  function automatic logic [PULSE_W-1:0] add_digit(input logic [PULSE_W-1:0] v,
                                                   input logic [7:0] c);
    logic [PULSE_W+3:0] n;
    n = (PULSE_W+4)'(v) * (PULSE_W+4)'(10) + (PULSE_W+4)'(4'(c - C_ZERO));
    return (n > (PULSE_W+4)'({PULSE_W{1'b1}})) ? {PULSE_W{1'b1}} : n[PULSE_W-1:0];
  endfunction

  phase_t               phase, phase_next;
  logic [PULSE_W-1:0]   chan, chan_next;
  logic [PULSE_W-1:0]   pulse, pulse_next;
  logic [2:0]           ridx, ridx_next;
  logic                 bad, bad_next;
  logic                 is_dig, is_ws, err;

  assign is_dig = (msg_byte >= C_ZERO) && (msg_byte <= C_NINE);
  assign is_ws  = (msg_byte == C_SPACE) || ((msg_byte >= C_TAB) && (msg_byte <= C_CR));

  always_comb begin
    phase_next = phase;
    chan_next  = chan;
    pulse_next = pulse;
    ridx_next  = ridx;
    bad_next   = bad;
    err        = 1'b0;
    if (!bad) begin
      err = 1'b1;
      case (phase)
        PH_START: begin
          if (msg_byte == C_HASH) begin
            phase_next = PH_CH1;
            err = 1'b0;
          end else if (msg_byte == C_R) begin
            ridx_next = 3'd1;
            phase_next = PH_RWORD;
            err = 1'b0;
          end
        end
        PH_RWORD: begin
          if (ridx < RWORD_LEN && msg_byte == rword_char(ridx)) begin
            ridx_next = ridx + 3'd1;
            err = 1'b0;
          end
        end
        PH_CH1, PH_CHN: begin
          if (is_dig) begin
            chan_next = add_digit(chan, msg_byte);
            phase_next = PH_CHN;
            err = 1'b0;
          end else if (phase == PH_CHN && is_ws) begin
            phase_next = PH_CHWS;
            err = 1'b0;
          end else if (phase == PH_CHN && msg_byte == C_P) begin
            phase_next = PH_P1;
            err = 1'b0;
          end
        end
        PH_CHWS: begin
          if (is_ws) begin
            err = 1'b0;
          end else if (msg_byte == C_P) begin
            phase_next = PH_P1;
            err = 1'b0;
          end
        end
        PH_P1, PH_PN: begin
          if (is_dig) begin
            pulse_next = add_digit(pulse, msg_byte);
            phase_next = PH_PN;
            err = 1'b0;
          end else if (phase == PH_PN && is_ws) begin
            phase_next = PH_PWS;
            err = 1'b0;
          end else if (phase == PH_PN && msg_byte == C_S) begin
            phase_next = PH_S1;
            err = 1'b0;
          end else if (phase == PH_PN && msg_byte == C_T) begin
            phase_next = PH_T1;
            err = 1'b0;
          end
        end
        PH_PWS: begin
          if (is_ws) begin
            err = 1'b0;
          end else if (msg_byte == C_S) begin
            phase_next = PH_S1;
            err = 1'b0;
          end else if (msg_byte == C_T) begin
            phase_next = PH_T1;
            err = 1'b0;
          end
        end
        PH_S1, PH_SN: begin
          if (is_dig) begin
            phase_next = PH_SN;
            err = 1'b0;
          end else if (phase == PH_SN && is_ws) begin
            phase_next = PH_SWS;
            err = 1'b0;
          end else if (phase == PH_SN && msg_byte == C_T) begin
            phase_next = PH_T1;
            err = 1'b0;
          end
        end
        PH_SWS: begin
          if (is_ws) begin
            err = 1'b0;
          end else if (msg_byte == C_T) begin
            phase_next = PH_T1;
            err = 1'b0;
          end
        end
        PH_T1, PH_TN: begin
          if (is_dig) begin
            phase_next = PH_TN;
            err = 1'b0;
          end
        end
        default: ;
      endcase
      if (err) begin
        bad_next = 1'b1;
      end
    end
  end

  // Message verdict from the state after this byte
  always_comb begin
    cmd.chan   = chan_next[CHAN_W-1:0];
    cmd.pulse  = pulse_next;
    cmd.status = ST_BAD;
    if (!bad_next) begin
      if (phase_next == PH_RWORD && ridx_next == RWORD_LEN) begin
        cmd.status = ST_RESET;
      end else if (phase_next == PH_PN || phase_next == PH_PWS ||
                   phase_next == PH_SN || phase_next == PH_TN) begin
        cmd.status = (chan_next <= PULSE_W'(CH_WRIST_ROT)) ? ST_JOINT : ST_UNKNOWN;
      end
    end
  end

  assign cmd_push = byte_accept && end_of_message;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      chan  <= '0;
      pulse <= '0;
      ridx  <= '0;
      bad   <= 1'b0;
    end else if (byte_accept) begin
      if (end_of_message) begin
        phase <= PH_START;
        chan  <= '0;
        pulse <= '0;
        ridx  <= '0;
        bad   <= 1'b0;
      end else begin
        phase <= phase_next;
        chan  <= chan_next;
        pulse <= pulse_next;
        ridx  <= ridx_next;
        bad   <= bad_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/scjd_cmd_fifo.sv
// Small command queue between the parser and the angle pipe.
// Uses scjd_pkg::cmd_t.
`default_nettype none

module scjd_cmd_fifo #(
  parameter int DEPTH = scjd_pkg::CMD_FIFO_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire scjd_pkg::cmd_t wr_cmd,
  output logic                full,
  input  wire logic           pop,
  output scjd_pkg::cmd_t      rd_cmd,
  output logic                not_empty
);
  import scjd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/scjd_angle_pipe.sv
// Back end: clamps the pulse, maps it to a Q2.F angle through a
// reciprocal-multiply divide, holds the joint angles. Uses scjd_pkg.
`default_nettype none

module scjd_angle_pipe #(
  parameter int ANGLE_FRAC_BITS = scjd_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire scjd_pkg::cmd_t                              head,
  input  wire logic                                        head_valid,
  output logic                                             pop,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output scjd_pkg::status_t                                out_status,
  output logic [scjd_pkg::NUM_JOINTS*scjd_pkg::ANGLE_W-1:0] out_angles
);
  import scjd_pkg::*;

  localparam int SH  = RAD_FRAC - ANGLE_FRAC_BITS;
  localparam int RPW = MP_W + RECIP_W;
  localparam int CPW = Q_W + DIFF_W;

  localparam int J_BASE = 0, J_SHLD = 1, J_ELBW = 2, J_WRST = 3;
  localparam int J_WROT = 4, J_GRPL = 5, J_GRPR = 6;

  logic advance;

  logic                 v1, v2, v3, v4;
  status_t              st1, st2, st3, st4;
  logic [CHAN_W-1:0]    ch1, ch2, ch3, ch4;
  logic [DIFF_W-1:0]    d1;
  logic [PROD_W-1:0]    prod2;
  logic [MP_W-1:0]      mp3, mp4;
  logic [Q_W-1:0]       q4;

  logic [PULSE_W-1:0]       lo_w, hi_w, pc;
  logic signed [N_W-1:0]    num, num_sh;
  logic [RPW-1:0]           rprod;
  logic [CPW-1:0]           back_prod;
  logic [Q_W-1:0]           q_fix;
  logic signed [Q_W:0]      ang_w;
  logic [ANGLE_W-1:0]       ang;

  logic [ANGLE_W-1:0]       joint [NUM_JOINTS];

  // Whole pipe moves together; the joint registers are the output register.
  assign advance = !out_valid || out_ready;
  assign pop     = advance && head_valid;

  // Stage 1: clamp to the window
  always_comb begin
    lo_w = PULSE_W'(win_lo(head.chan));
    hi_w = PULSE_W'(win_hi(head.chan));
    if (head.pulse > hi_w) begin
      pc = hi_w;
    end else if (head.pulse < lo_w) begin
      pc = lo_w;
    end else begin
      pc = head.pulse;
    end
  end

  // Stage 3: numerator, scale shift, positive bias of span * 2^16
  always_comb begin
    num    = a_coef(ch2, ANGLE_FRAC_BITS) + $signed({{(N_W-PROD_W){1'b0}}, prod2});
    num_sh = (num >>> SH) + $signed(N_W'(win_span(ch2)) << OFF_SHIFT);
  end

  // Stage 4: quotient estimate, at most one too large
  assign rprod = RPW'(mp3) * RPW'(span_recip(ch3));

  // Output stage: one-step correction, remove bias, saturate
  always_comb begin
    back_prod = CPW'(q4) * CPW'(win_span(ch4));
    q_fix     = (back_prod > CPW'(mp4)) ? q4 - Q_W'(1) : q4;
    ang_w     = $signed({1'b0, q_fix}) - $signed((Q_W+1)'(1 << OFF_SHIFT));
    if (ang_w > $signed((Q_W+1)'(ANGLE_MAX))) begin
      ang = ANGLE_W'(ANGLE_MAX);
    end else if (ang_w < $signed((Q_W+1)'(ANGLE_MIN))) begin
      ang = ANGLE_W'(ANGLE_MIN);
    end else begin
      ang = ang_w[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= head_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st1   <= head.status;
      ch1   <= head.chan;
      d1    <= DIFF_W'(pc - lo_w);
      st2   <= st1;
      ch2   <= ch1;
      prod2 <= PROD_W'(rad_span(ch1)) * PROD_W'(d1);
      st3   <= st2;
      ch3   <= ch2;
      mp3   <= MP_W'(num_sh);
      st4   <= st3;
      ch4   <= ch3;
      mp4   <= mp3;
      q4    <= Q_W'(rprod >> RECIP_SHIFT);
      if (v4) begin
        out_status <= st4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        joint[i] <= '0;
      end
    end else if (advance && v4) begin
      case (st4)
        ST_RESET: begin
          for (int i = 0; i < NUM_JOINTS; i++) begin
            joint[i] <= '0;
          end
        end
        ST_JOINT: begin
          case (ch4)
            CH_BASE:      joint[J_BASE] <= ang;
            CH_SHOULDER:  joint[J_SHLD] <= ang;
            CH_ELBOW:     joint[J_ELBW] <= ang;
            CH_WRIST:     joint[J_WRST] <= ang;
            CH_WRIST_ROT: joint[J_WROT] <= ang;
            CH_GRIPPER: begin
              joint[J_GRPL] <= ang;
              joint[J_GRPR] <= ang;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_JOINTS; i++) begin
      out_angles[i*ANGLE_W +: ANGLE_W] = joint[i];
    end
  end

endmodule

`default_nettype wire

// File: design/servo_command_joint_decoder_top.sv
// Top level of the servo command joint decoder.
// Depends on scjd_pkg, scjd_parser, scjd_cmd_fifo, scjd_angle_pipe.
`default_nettype none

// Servo command joint decoder. Text command messages ("#<ch> P<pulse>
// [S<speed>] [T<time>]" or "RESET") stream in one ASCII word per cycle on
// s_axis, with tlast on the final byte of each message. Every message yields
// exactly one result word on m_axis: tuser carries the status (joint
// updated, reset, malformed or multi-servo, unknown channel) and tdata the
// full set of seven joint angles as they stand after the message, signed
// Q2.ANGLE_FRAC_BITS radians. Throughput is one input word per cycle while
// the command queue is not full; the byte parser handles one character per
// cycle. Completed messages enter a CMD_FIFO_DEPTH-entry command queue; the
// five-stage angle pipe (clamp, slope multiply, scale, reciprocal multiply,
// correct and store) drains it at one command per cycle when the output is
// not stalled. s_axis_tready drops only when the queue is full, which takes
// a sustained m_axis stall. Pulses are clamped to each channel's window;
// channel 4 (gripper) writes both gripper outputs, channel 5 the wrist
// rotate joint. Numbers saturate at 65535.
module servo_command_joint_decoder_top #(
  parameter int ANGLE_FRAC_BITS = scjd_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CMD_FIFO_DEPTH  = scjd_pkg::CMD_FIFO_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // input stream
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,   // [7:0] msg_byte
  input  wire logic          s_axis_tlast,   // end_of_message
  // result stream
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // [15:0] angle_base, [31:16] angle_shoulder, [47:32] angle_elbow,
  // [63:48] angle_wrist, [79:64] angle_wrist_rotate, [95:80] gripper_left,
  // [111:96] gripper_right
  output logic [111:0]       m_axis_tdata,
  output logic [1:0]         m_axis_tuser    // [1:0] status
);
  import scjd_pkg::*;

  logic     byte_accept;
  logic     cmd_push, fifo_full, fifo_pop, fifo_not_empty;
  cmd_t     push_cmd, head_cmd;
  status_t  res_status;

  assign s_axis_tready = !fifo_full;
  assign byte_accept   = s_axis_tvalid && s_axis_tready;

  scjd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .byte_accept    (byte_accept),
    .msg_byte       (s_axis_tdata),
    .end_of_message (s_axis_tlast),
    .cmd_push       (cmd_push),
    .cmd            (push_cmd)
  );

  scjd_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .wr_cmd    (push_cmd),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .rd_cmd    (head_cmd),
    .not_empty (fifo_not_empty)
  );

  scjd_angle_pipe #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .head       (head_cmd),
    .head_valid (fifo_not_empty),
    .pop        (fifo_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (res_status),
    .out_angles (m_axis_tdata)
  );

  assign m_axis_tuser = res_status;

  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !fifo_full)
    else $error("command queue overflow");

  // Queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> fifo_not_empty)
    else $error("command queue underflow");

  // A reset result shows all joints cleared
  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ST_RESET) |-> (m_axis_tdata == '0))
    else $error("reset result with nonzero joints");

  // Both gripper fingers always carry the same value
  a_grip_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[95:80] == m_axis_tdata[111:96]))
    else $error("gripper outputs differ");

endmodule

`default_nettype wire
